// File: rtl/twims_pkg.sv
package twims_pkg;

	localparam int BUFFER_DEPTH_DEF = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [3:0] ST_START       = 4'd0;
	localparam logic [3:0] ST_REPSTART    = 4'd1;
	localparam logic [3:0] ST_ADDRW_ACK   = 4'd2;
	localparam logic [3:0] ST_DATATX_ACK  = 4'd3;
	localparam logic [3:0] ST_DATARX_ACK  = 4'd4;
	localparam logic [3:0] ST_ADDRR_ACK   = 4'd5;
	localparam logic [3:0] ST_DATARX_NACK = 4'd6;
	localparam logic [3:0] ST_ADDRW_NACK  = 4'd7;
	localparam logic [3:0] ST_ADDRR_NACK  = 4'd8;
	localparam logic [3:0] ST_DATATX_NACK = 4'd9;
	localparam logic [3:0] ST_BUS_ERROR   = 4'd10;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_TX      = 3'd2;
	localparam logic [2:0] CMD_RX_ACK  = 3'd3;
	localparam logic [2:0] CMD_RX_NACK = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;
	localparam logic [2:0] CMD_RELEASE = 3'd6;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TX_NACK = 3'd1;
	localparam logic [2:0] ERR_BUS     = 3'd2;
	localparam logic [2:0] ERR_OTHER   = 3'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] index;
		logic [7:0] data_in;
		logic [5:0] length;
		logic [3:0] bus_status;
	} item_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       done_res;
		logic       success;
		logic [2:0] error_code;
		logic [7:0] read_byte;
	} result_t;

	typedef struct packed {
		logic [2:0] command;
		logic       done_res;
		logic       success;
		logic [2:0] error_code;
		logic       sel_tx;
		logic       sel_rd;
	} decision_t;

endpackage

// File: rtl/twims_ram.sv
module twims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/twims_ctrl.sv
module twims_ctrl #(
	parameter int BUFFER_DEPTH = twims_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  twims_pkg::item_t                item,
	output logic                            ram_we,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
	output twims_pkg::decision_t            dec
);

	import twims_pkg::*;

	localparam int AW    = $clog2(BUFFER_DEPTH);
	localparam int PTR_W = $clog2(BUFFER_DEPTH + 1);
	localparam int CW    = (PTR_W > 6) ? PTR_W : 6;

	logic [PTR_W-1:0] ptr_q, ptr_n;
	logic [PTR_W-1:0] len_q, len_n;
	logic             ok_q, ok_n;
	logic [2:0]       err_q, err_n;
	logic             idx_in_range;

	assign idx_in_range = CW'(item.index) < CW'(BUFFER_DEPTH);

	always_comb begin
		logic [PTR_W-1:0] p;
		p            = ptr_q;
		ptr_n        = ptr_q;
		len_n        = len_q;
		ok_n         = ok_q;
		err_n        = err_q;
		ram_we       = 1'b0;
		ram_waddr    = AW'(item.index);
		ram_wdata    = item.data_in;
		ram_re       = 1'b0;
		ram_raddr    = AW'(item.index);
		dec.command  = CMD_NONE;
		dec.done_res = 1'b0;
		dec.sel_tx   = 1'b0;
		dec.sel_rd   = 1'b0;
		case (item.operation)
			OP_LOAD: begin
				ram_we = idx_in_range;
			end
			OP_START: begin
				len_n = (CW'(item.length) > CW'(BUFFER_DEPTH)) ?
					PTR_W'(BUFFER_DEPTH) : PTR_W'(item.length);
				ok_n        = 1'b0;
				err_n       = ERR_NONE;
				dec.command = CMD_START;
			end
			OP_STATUS: begin
				case (item.bus_status)
					ST_START, ST_REPSTART, ST_ADDRW_ACK, ST_DATATX_ACK: begin
						if (item.bus_status == ST_START || item.bus_status == ST_REPSTART) begin
							p = '0;
						end
						if (p < len_q) begin
							ram_re      = 1'b1;
							ram_raddr   = p[AW-1:0];
							dec.sel_tx  = 1'b1;
							ptr_n       = PTR_W'(p + 1'b1);
							dec.command = CMD_TX;
						end else begin
							ptr_n        = p;
							ok_n         = 1'b1;
							dec.command  = CMD_STOP;
							dec.done_res = 1'b1;
						end
					end
					ST_DATARX_ACK, ST_ADDRR_ACK: begin
						if (item.bus_status == ST_DATARX_ACK && p < PTR_W'(BUFFER_DEPTH)) begin
							ram_we    = 1'b1;
							ram_waddr = p[AW-1:0];
							p         = PTR_W'(p + 1'b1);
						end
						ptr_n = p;
						dec.command = ((PTR_W+1)'(p) + (PTR_W+1)'(1) < (PTR_W+1)'(len_q)) ?
							CMD_RX_ACK : CMD_RX_NACK;
					end
					ST_DATARX_NACK: begin
						ram_we       = p < PTR_W'(BUFFER_DEPTH);
						ram_waddr    = p[AW-1:0];
						ok_n         = 1'b1;
						dec.command  = CMD_STOP;
						dec.done_res = 1'b1;
					end
					ST_ADDRW_NACK, ST_ADDRR_NACK: begin
						ok_n        = 1'b0;
						err_n       = ERR_NONE;
						dec.command = CMD_START;
					end
					default: begin
						ok_n = 1'b0;
						if (item.bus_status == ST_DATATX_NACK) begin
							err_n = ERR_TX_NACK;
						end else if (item.bus_status == ST_BUS_ERROR) begin
							err_n = ERR_BUS;
						end else begin
							err_n = ERR_OTHER;
						end
						dec.command  = CMD_RELEASE;
						dec.done_res = 1'b1;
					end
				endcase
			end
			default: begin
				ram_re     = idx_in_range;
				dec.sel_rd = idx_in_range;
			end
		endcase
		dec.success    = ok_n;
		dec.error_code = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			len_q <= '0;
			ok_q  <= 1'b0;
			err_q <= ERR_NONE;
		end else if (fire) begin
			ptr_q <= ptr_n;
			len_q <= len_n;
			ok_q  <= ok_n;
			err_q <= err_n;
		end
	end

endmodule

// File: rtl/twi_master_transfer_sequencer.sv
// two-wire bus master transfer sequencer
// item channel (item_valid / item_ready / item): one operation per item,
//   load buffer byte, start transfer, bus status event or read buffer byte
// result channel (result_valid / result_ready / result): exactly one result
//   per item, in order; command to the bus engine, byte to transmit,
//   done / success / error code and the byte of a buffer read
// an accepted item passes through the input register, then the result register
//   with the buffer read port, before its result is valid
// throughput: one item per cycle while the receiver does not stall, set by the
//   single decode stage and the one write plus one read port of the message buffer
// reset clears the pipeline, byte pointer, message length, success flag and
//   error code; message buffer contents are undefined until loaded
// when the receiver stalls, the result register holds its item and one more
//   item can wait in the input register; item_ready then drops until
//   result_ready returns
module twi_master_transfer_sequencer #(
	parameter int BUFFER_DEPTH = twims_pkg::BUFFER_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  twims_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output twims_pkg::result_t result
);

	import twims_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	item_t     item_s1;
	logic      valid_s1;
	decision_t dec;
	decision_t dec_s2;
	logic      valid_s2;
	logic      advance;
	logic      fire;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign advance    = !valid_s2 || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (fire) begin
			dec_s2 <= dec;
		end
	end

	twims_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.dec      (dec)
	);

	twims_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (ram_we && fire),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re && fire),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign result_valid      = valid_s2;
	assign result.command    = dec_s2.command;
	assign result.tx_byte    = dec_s2.sel_tx ? ram_rdata : 8'd0;
	assign result.done_res   = dec_s2.done_res;
	assign result.success    = dec_s2.success;
	assign result.error_code = dec_s2.error_code;
	assign result.read_byte  = dec_s2.sel_rd ? ram_rdata : 8'd0;

`ifndef ASSERT_OFF
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready && valid_s1))
		else $error("item_ready low without a stalled result");

	a_done_ends_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.done_res) |->
		(result.command == CMD_STOP || result.command == CMD_RELEASE))
		else $error("done without stop or release");

	a_tx_byte_only_on_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.command != CMD_TX) |-> (result.tx_byte == 8'd0))
		else $error("tx byte on a non-transmit command");

	a_read_needs_buffer_read: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && dec.sel_rd) |-> ram_re)
		else $error("buffer read result without a read access");
`endif

endmodule

// File: sim/tb_twi_master_transfer_sequencer.sv
`timescale 1ns / 1ps

module tb_twi_master_transfer_sequencer;

	import twims_pkg::*;

	localparam int DEPTH = BUFFER_DEPTH_DEF;
	localparam int ITEM_TARGET = 1500;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 10;

	// status codes past bus error all mean other status
	localparam logic [3:0] ST_OTHER     = 4'd11;
	localparam logic [3:0] ST_TOP_CODE  = 4'd15;

	typedef struct {
		item_t   it;
		result_t want;
	} stimulus_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// predicted sequencer state
	logic [7:0] msg_buf [DEPTH];
	bit         buf_written [DEPTH];
	int         byte_ptr = 0;
	int         msg_len = 0;
	logic       xfer_ok = 1'b0;
	logic [2:0] last_err = ERR_NONE;

	stimulus_t pending_items[$];
	result_t   awaited_results[$];
	stimulus_t offered;
	result_t   want;

	int   send_gap = 0;
	int   stall_left = 0;
	bit   tx_eager = 1'b0;
	bit   rx_eager = 1'b0;
	logic hold_off = 1'b0;

	int items_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int stops_seen = 0;
	int releases_seen = 0;
	int starts_seen = 0;

	twi_master_transfer_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic result_t sequencer_response(item_t it);
		result_t r;
		r = '0;
		case (it.operation)
			OP_LOAD: begin
				msg_buf[it.index] = it.data_in;
				buf_written[it.index] = 1'b1;
			end
			OP_START: begin
				msg_len = (it.length > DEPTH) ? DEPTH : int'(it.length);
				xfer_ok = 1'b0;
				last_err = ERR_NONE;
				r.command = CMD_START;
			end
			OP_STATUS: begin
				case (it.bus_status)
					ST_START, ST_REPSTART, ST_ADDRW_ACK, ST_DATATX_ACK: begin
						if (it.bus_status <= ST_REPSTART) begin
							byte_ptr = 0;
						end
						if (byte_ptr < msg_len) begin
							r.command = CMD_TX;
							r.tx_byte = msg_buf[byte_ptr];
							byte_ptr++;
						end else begin
							xfer_ok = 1'b1;
							r.command = CMD_STOP;
							r.done_res = 1'b1;
						end
					end
					ST_DATARX_ACK, ST_ADDRR_ACK: begin
						if (it.bus_status == ST_DATARX_ACK && byte_ptr < DEPTH) begin
							msg_buf[byte_ptr] = it.data_in;
							buf_written[byte_ptr] = 1'b1;
							byte_ptr++;
						end
						r.command = (byte_ptr + 1 < msg_len) ? CMD_RX_ACK : CMD_RX_NACK;
					end
					ST_DATARX_NACK: begin
						if (byte_ptr < DEPTH) begin
							msg_buf[byte_ptr] = it.data_in;
							buf_written[byte_ptr] = 1'b1;
						end
						xfer_ok = 1'b1;
						r.command = CMD_STOP;
						r.done_res = 1'b1;
					end
					ST_ADDRW_NACK, ST_ADDRR_NACK: begin
						xfer_ok = 1'b0;
						last_err = ERR_NONE;
						r.command = CMD_START;
					end
					default: begin
						xfer_ok = 1'b0;
						last_err = (it.bus_status == ST_DATATX_NACK) ? ERR_TX_NACK :
							(it.bus_status == ST_BUS_ERROR) ? ERR_BUS : ERR_OTHER;
						r.command = CMD_RELEASE;
						r.done_res = 1'b1;
					end
				endcase
			end
			default: begin
				r.read_byte = msg_buf[it.index];
			end
		endcase
		r.success = xfer_ok;
		r.error_code = last_err;
		return r;
	endfunction

	// buffer entry this item would read before it was ever written, else -1
	function automatic int unwritten_entry(item_t it);
		int at;
		at = -1;
		if (it.operation == OP_READ && !buf_written[it.index]) begin
			at = int'(it.index);
		end
		if (it.operation == OP_STATUS && it.bus_status <= ST_DATATX_ACK) begin
			at = (it.bus_status <= ST_REPSTART) ? 0 : byte_ptr;
			if (at >= msg_len || buf_written[at]) begin
				at = -1;
			end
		end
		return at;
	endfunction

	function automatic item_t random_fields();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(item_t)-1:0];
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	task automatic push_item(item_t it);
		stimulus_t s;
		int hole;
		hole = unwritten_entry(it);
		if (hole >= 0) begin
			s.it = random_fields();
			s.it.operation = OP_LOAD;
			s.it.index = 5'(hole);
			s.want = sequencer_response(s.it);
			pending_items.push_back(s);
		end
		s.it = it;
		s.want = sequencer_response(it);
		pending_items.push_back(s);
	endtask

	task automatic send_load(int idx, int d);
		item_t it;
		it = random_fields();
		it.operation = OP_LOAD;
		it.index = 5'(idx);
		it.data_in = 8'(d);
		push_item(it);
	endtask

	task automatic send_start(int len);
		item_t it;
		it = random_fields();
		it.operation = OP_START;
		it.length = 6'(len);
		push_item(it);
	endtask

	task automatic send_status(logic [3:0] st);
		item_t it;
		it = random_fields();
		it.operation = OP_STATUS;
		it.bus_status = st;
		push_item(it);
	endtask

	task automatic send_read(int idx);
		item_t it;
		it = random_fields();
		it.operation = OP_READ;
		it.index = 5'(idx);
		push_item(it);
	endtask

	task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				awaited_results.push_back(offered.want);
				items_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered = pending_items.pop_front();
					item <= offered.it;
					item_valid <= 1'b1;
					if ($urandom_range(0, 99) == 0) tx_eager = !tx_eager;
					send_gap = (tx_eager || $urandom_range(0, 2) != 0) ? 0 : idle_len();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited, expected none, got %p",
						$time, result);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("command", 8'(want.command), 8'(result.command));
					check_field("tx_byte", want.tx_byte, result.tx_byte);
					check_field("done_res", 8'(want.done_res), 8'(result.done_res));
					check_field("success", 8'(want.success), 8'(result.success));
					check_field("error_code", 8'(want.error_code), 8'(result.error_code));
					check_field("read_byte", want.read_byte, result.read_byte);
					results_checked++;
					if (want.command == CMD_STOP) stops_seen++;
					if (want.command == CMD_RELEASE) releases_seen++;
					if (want.command == CMD_START) starts_seen++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!rx_eager && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !hold_off;
			end
			if ($urandom_range(0, 199) == 0) rx_eager = !rx_eager;
		end
	end

	// long receiver hold-off so the pipeline fills and backs up the input
	initial begin
		while (items_accepted < 300) @(negedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int len;
		int n;
		int fault;
		int extra;
		int pick;
		bit aborted;

		// directed
		send_status(ST_DATATX_ACK);
		send_status(ST_DATARX_ACK);
		send_read(0);
		send_load(0, 8'h00);
		send_load(31, 8'hff);
		send_load(1, 8'h5a);
		send_read(31);
		send_read(1);
		send_start(63);
		send_start(3);
		send_status(ST_START);
		send_status(ST_ADDRW_ACK);
		send_status(ST_DATATX_ACK);
		send_status(ST_DATATX_ACK);
		send_status(ST_ADDRW_NACK);
		send_status(ST_REPSTART);
		send_status(ST_ADDRR_NACK);
		send_status(ST_DATATX_NACK);
		send_status(ST_BUS_ERROR);
		send_status(ST_OTHER);
		send_status(ST_TOP_CODE);
		send_start(0);
		send_status(ST_ADDRR_ACK);
		send_status(ST_DATARX_NACK);

		// random transfers with some noise
		while (pending_items.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 32);
			n = (len > DEPTH) ? DEPTH : len;
			fault = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
			aborted = 1'b0;
			if (pick < 45) begin
				// write transfer
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 1) == 0) send_load(i, $urandom_range(0, 255));
				end
				send_start(len);
				send_status($urandom_range(0, 1) ? ST_START : ST_REPSTART);
				for (int i = 0; i < n && !aborted; i++) begin
					if (i == fault) begin
						case ($urandom_range(0, 3))
							0: begin
								send_status(ST_ADDRW_NACK);
								send_status(ST_START);
							end
							1: send_status(ST_DATATX_NACK);
							2: send_status(ST_BUS_ERROR);
							default: send_status(ST_OTHER + 4'($urandom_range(0, 4)));
						endcase
						aborted = (last_err != ERR_NONE);
					end else begin
						send_status((i == 0) ? ST_ADDRW_ACK : ST_DATATX_ACK);
					end
				end
			end else if (pick < 75) begin
				// read transfer
				send_load(0, $urandom_range(0, 255));
				send_start(len);
				send_status($urandom_range(0, 1) ? ST_START : ST_REPSTART);
				send_status(ST_ADDRR_ACK);
				extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
				for (int i = 0; i < n - 2 + extra && !aborted; i++) begin
					if (i == fault) begin
						case ($urandom_range(0, 2))
							0: begin
								send_status(ST_ADDRR_NACK);
								send_status(ST_START);
							end
							1: send_status(ST_BUS_ERROR);
							default: send_status(ST_OTHER + 4'($urandom_range(0, 4)));
						endcase
						aborted = (last_err != ERR_NONE);
					end else begin
						send_status(ST_DATARX_ACK);
					end
				end
				if (!aborted) send_status(ST_DATARX_NACK);
				repeat ($urandom_range(0, 3)) send_read($urandom_range(0, n - 1));
			end else begin
				push_item(random_fields());
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d items and %0d checked results", items_accepted,
			results_checked);
		$display("transfers ended: %0d by stop, %0d by release; %0d start commands",
			stops_seen, releases_seen, starts_seen);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
